>>> src/cswin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswin_pkg: shared types and constants
// Request and result payloads, store sizes and the ALU request struct for the
// start-window block.
// ----------------------------------------------------------------------------
package cswin_pkg;

	localparam int MAX_OPS = 64;
	localparam int IDX_W   = $clog2(MAX_OPS);
	localparam int CNT_W   = $clog2(MAX_OPS + 1);
	localparam int TW      = 24;   // time field width on the request side
	localparam int SW      = 32;   // signed start width on the result side

	typedef struct packed {
		logic [TW-1:0] lower_bound;
		logic [TW-1:0] upper_bound;
		logic [TW-1:0] duration;
		logic          has_deadline;
		logic [TW-1:0] deadline;
		logic          path_end;
	} op_t;

	typedef struct packed {
		logic signed [SW-1:0] earliest;
		logic signed [SW-1:0] latest;
		logic                 final_item;
	} win_t;

	// one add or subtract, followed by a signed compare against c
	typedef struct packed {
		logic signed [SW-1:0] a;
		logic [TW-1:0]        b;
		logic                 sub;
		logic signed [SW-1:0] c;
	} alu_req_t;

	typedef struct packed {
		logic signed [SW:0] sum;
		logic               sum_lt_c;
		logic               c_lt_sum;
	} alu_rsp_t;

endpackage

>>> src/cswin_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswin_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cswin_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/cswin_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswin_alu: shared add/subtract and compare unit
// Computes a +/- b at 33 bits and compares the result with c, both ways.
// ----------------------------------------------------------------------------
module cswin_alu (
	input  cswin_pkg::alu_req_t req,
	output cswin_pkg::alu_rsp_t rsp
);
	import cswin_pkg::*;

	logic signed [SW:0] a_x;
	logic signed [SW:0] b_x;
	logic signed [SW:0] c_x;
	logic signed [SW:0] sum;

	assign a_x = {req.a[SW-1], req.a};
	assign b_x = {{(SW + 1 - TW){1'b0}}, req.b};
	assign c_x = {req.c[SW-1], req.c};
	assign sum = req.sub ? (a_x - b_x) : (a_x + b_x);

	assign rsp.sum      = sum;
	assign rsp.sum_lt_c = sum < c_x;
	assign rsp.c_lt_sum = c_x < sum;

endmodule

>>> src/chain_start_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chain_start_window: earliest/latest start windows along one path
// Forward pass on load, backward deadline walk, ordered emission at path end.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------
//  op      | in  | op_valid/op_stall  | op_t  one path operation
//  win     | out | win_valid/win_stall| win_t one start window per op
//
// Steps: a request is accepted in idle, then stored in one load step; the
//   deadline walk then visits predecessors, the one that stops the walk
//   included, each with a read of duration/latest, then subtract/compare/
//   write through the one shared ALU; each window is emitted by a RAM read,
//   an output load and a handoff that waits while win_stall is high.
// Reset: arst_n clears the sequencer, the op count and win_valid; the stores
//   are written before they are read and need no clearing.
// Stalls: op_stall is high whenever the sequencer is busy; win_stall holds the
//   output register and the emission walk in place.
// ----------------------------------------------------------------------------
module chain_start_window (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	output logic            op_stall,
	input  cswin_pkg::op_t  op,
	output logic            win_valid,
	input  logic            win_stall,
	output cswin_pkg::win_t win
);
	import cswin_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_WRD   = 3'd2;
	localparam logic [2:0] S_WCMP  = 3'd3;
	localparam logic [2:0] S_ERD   = 3'd4;
	localparam logic [2:0] S_EWAIT = 3'd5;
	localparam logic [2:0] S_EOUT  = 3'd6;

	logic [2:0]           state_q;
	op_t                  op_q;
	logic [CNT_W-1:0]     cnt_q;       // ops stored for the current path
	logic signed [SW-1:0] prev_e_q;    // earliest start of last stored op
	logic [TW-1:0]        prev_d_q;    // duration of last stored op
	logic [IDX_W-1:0]     j_q;         // backward walk position
	logic signed [SW-1:0] cur_l_q;     // latest start at position j
	logic [IDX_W-1:0]     k_q;         // emission position
	win_t                 win_q;
	logic                 win_valid_q;

	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;

	// store ports
	logic                 dur_we;
	logic                 ear_we;
	logic                 lat_we;
	logic [IDX_W-1:0]     w_addr;
	logic [IDX_W-1:0]     r_addr;
	logic signed [SW-1:0] ear_wdata;
	logic signed [SW-1:0] lat_wdata;
	logic [TW-1:0]        dur_rd;
	logic [SW-1:0]        ear_rd;
	logic [SW-1:0]        lat_rd;

	logic                 not_full;
	logic                 walk;
	logic signed [SW-1:0] lb_x;
	logic signed [SW-1:0] e_new;
	logic [CNT_W-1:0]     k_next;

	assign not_full = cnt_q < CNT_W'(MAX_OPS);
	assign lb_x     = {{(SW - TW){1'b0}}, op_q.lower_bound};
	// a deadline only matters past the first op and when it is tighter
	assign walk     = (cnt_q != '0) && op_q.has_deadline
	                  && (op_q.deadline < op_q.upper_bound);
	assign e_new    = alu_rsp.c_lt_sum ? alu_rsp.sum[SW-1:0] : lb_x;
	assign k_next   = CNT_W'(k_q) + CNT_W'(1);

	// the one ALU: forward chain add on load, backward push subtract on walk
	always_comb begin
		if (state_q == S_WCMP) begin
			alu_req.a   = cur_l_q;
			alu_req.b   = dur_rd;
			alu_req.sub = 1'b1;
			alu_req.c   = lat_rd;
		end else begin
			alu_req.a   = prev_e_q;
			alu_req.b   = prev_d_q;
			alu_req.sub = 1'b0;
			alu_req.c   = lb_x;
		end
	end

	cswin_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_comb begin
		dur_we    = 1'b0;
		ear_we    = 1'b0;
		lat_we    = 1'b0;
		w_addr    = cnt_q[IDX_W-1:0];
		ear_wdata = e_new;
		lat_wdata = walk ? {{(SW - TW){1'b0}}, op_q.deadline}
		                 : {{(SW - TW){1'b0}}, op_q.upper_bound};
		r_addr    = (state_q == S_WRD) ? (j_q - IDX_W'(1)) : k_q;
		case (state_q)
			S_LOAD: begin
				dur_we = not_full;
				ear_we = not_full;
				lat_we = not_full;
			end
			S_WCMP: begin
				w_addr    = j_q - IDX_W'(1);
				lat_wdata = alu_rsp.sum[SW-1:0];
				lat_we    = alu_rsp.sum_lt_c;
			end
			default: begin
			end
		endcase
	end

	cswin_ram #(.WIDTH(TW), .DEPTH(MAX_OPS)) u_dur (
		.clk   (clk),
		.we    (dur_we),
		.waddr (w_addr),
		.wdata (op_q.duration),
		.raddr (r_addr),
		.rdata (dur_rd)
	);

	cswin_ram #(.WIDTH(SW), .DEPTH(MAX_OPS)) u_ear (
		.clk   (clk),
		.we    (ear_we),
		.waddr (w_addr),
		.wdata (ear_wdata),
		.raddr (r_addr),
		.rdata (ear_rd)
	);

	cswin_ram #(.WIDTH(SW), .DEPTH(MAX_OPS)) u_lat (
		.clk   (clk),
		.we    (lat_we),
		.waddr (w_addr),
		.wdata (lat_wdata),
		.raddr (r_addr),
		.rdata (lat_rd)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && op_valid) begin
			op_q <= op;
		end
		if (state_q == S_LOAD && walk) begin
			j_q     <= cnt_q[IDX_W-1:0];
			cur_l_q <= {{(SW - TW){1'b0}}, op_q.deadline};
		end
		if (state_q == S_WCMP) begin
			j_q     <= j_q - IDX_W'(1);
			cur_l_q <= alu_rsp.sum[SW-1:0];
		end
		if (state_q == S_EWAIT) begin
			win_q.earliest   <= ear_rd;
			win_q.latest     <= lat_rd;
			win_q.final_item <= (k_next == cnt_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			prev_e_q    <= '0;
			prev_d_q    <= '0;
			k_q         <= '0;
			win_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					k_q <= '0;
					if (not_full) begin
						prev_e_q <= e_new;
						prev_d_q <= op_q.duration;
						cnt_q    <= cnt_q + CNT_W'(1);
						if (walk) begin
							state_q <= S_WRD;
						end else if (op_q.path_end) begin
							state_q <= S_ERD;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						// path full: drop the op, still flush on path end
						state_q <= op_q.path_end ? S_ERD : S_IDLE;
					end
				end
				S_WRD: begin
					state_q <= S_WCMP;
				end
				S_WCMP: begin
					if (alu_rsp.sum_lt_c && j_q != IDX_W'(1)) begin
						state_q <= S_WRD;
					end else if (op_q.path_end) begin
						state_q <= S_ERD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ERD: begin
					state_q <= S_EWAIT;
				end
				S_EWAIT: begin
					win_valid_q <= 1'b1;
					state_q     <= S_EOUT;
				end
				S_EOUT: begin
					if (!win_stall) begin
						win_valid_q <= 1'b0;
						if (k_next == cnt_q) begin
							cnt_q    <= '0;
							prev_e_q <= '0;
							prev_d_q <= '0;
							state_q  <= S_IDLE;
						end else begin
							k_q     <= k_q + IDX_W'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign op_stall  = (state_q != S_IDLE);
	assign win_valid = win_valid_q;
	assign win       = win_q;

endmodule
